>>> src/sbqm_pkg.sv
// package for the stereo biquad cascade mixer
// register indexes, section codes, widths; used by the top level, not by sbqm_ram
package sbqm_pkg;
  localparam int CHANNELS_DEF    = 2;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int NUM_SECT  = 5;
  localparam int COEF_BITS = 20;
  localparam int COEF_FRAC = 17;
  localparam int REG_BITS  = 60;
  localparam int IDX_BITS  = 3;
  localparam int ACC_BITS  = 64;

  // register indexes
  localparam logic [IDX_BITS-1:0] REG_HP   = 3'd0;
  localparam logic [IDX_BITS-1:0] REG_LP   = 3'd1;
  localparam logic [IDX_BITS-1:0] REG_BP   = 3'd2;
  localparam logic [IDX_BITS-1:0] REG_NO   = 3'd3;
  localparam logic [IDX_BITS-1:0] REG_PAR  = 3'd4;
  localparam logic [IDX_BITS-1:0] REG_MASK = 3'd5;

  // section codes
  localparam logic [2:0] SEC_HP  = 3'd0;
  localparam logic [2:0] SEC_LP  = 3'd1;
  localparam logic [2:0] SEC_BP  = 3'd2;
  localparam logic [2:0] SEC_NO  = 3'd3;
  localparam logic [2:0] SEC_PAR = 3'd4;

  // history tap codes
  localparam logic [1:0] TAP_X1 = 2'd0;
  localparam logic [1:0] TAP_X2 = 2'd1;
  localparam logic [1:0] TAP_Y1 = 2'd2;
  localparam logic [1:0] TAP_Y2 = 2'd3;
endpackage

>>> src/stereo_biquad_cascade_mixer.sv
// top level of the stereo biquad cascade mixer: sequencer, one shared mac
// depends on sbqm_pkg and sbqm_ram
//
// channel | signals                                | direction
// in      | in_valid in_ready sample_in channel    | request in
// out     | out_valid out_ready sample_out         | request out
// cfg     | cfg_valid cfg_ready cfg_index cfg_data | register write
//
// after acceptance the sequencer steps through ST_SEL to find the first enabled
// section, then per enabled section does a read setup, five mac steps and four
// history writes, and finally raises out_valid from ST_DONE; the work is
// serialised by the single 21x32 multiplier and the one history ram.
// after reset a clearing pass zeroes all CHANNELS*20 words of the history ram;
// requests wait for it. while a result waits in the output register no new
// request is taken.
module stereo_biquad_cascade_mixer
  import sbqm_pkg::*;
#(
  parameter int CHANNELS    = CHANNELS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  input  logic                          channel,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [IDX_BITS-1:0]           cfg_index,
  input  logic [REG_BITS-1:0]           cfg_data
);
  localparam int DEPTH = CHANNELS * NUM_SECT * 4;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CFW   = COEF_BITS + 1;
  localparam logic signed [SAMPLE_BITS-1:0] FULL = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_SEL   = 7'b0000100,
    ST_RD    = 7'b0001000,
    ST_MAC   = 7'b0010000,
    ST_WB    = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

  state_t state;
  logic [REG_BITS-1:0] coefs [NUM_SECT];
  logic [4:0] enable_mask;
  logic [AW-1:0] clr_addr;
  logic [CW-1:0] ch;
  logic [2:0] sec;
  logic [2:0] step;
  logic signed [31:0] xin, xcur, ycas, h0, h2;
  logic signed [ACC_BITS-1:0] acc;
  logic signed [SAMPLE_BITS-1:0] res;

  // ram ports
  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0] wdata, rdata;

  sbqm_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_hist (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  function automatic logic [AW-1:0] hist_addr(logic [CW-1:0] c, logic [2:0] s,
                                              logic [1:0] t);
    return AW'((32'(c) * NUM_SECT + 32'(s)) * 4 + 32'(t));
  endfunction

  // coefficient selection for the current step, one bit wider so negation holds
  logic signed [CFW-1:0] b0, a1, a2, cf;
  logic signed [31:0] dat;
  logic [1:0] tap;
  always_comb begin
    b0 = CFW'($signed(coefs[sec][19:0]));
    a1 = CFW'($signed(coefs[sec][39:20]));
    a2 = CFW'($signed(coefs[sec][59:40]));
    cf = '0;
    dat = '0;
    tap = TAP_X1;
    case (step)
      3'd0: begin cf = b0; dat = xcur; tap = TAP_X1; end
      3'd1: begin
        tap = TAP_X1; dat = rdata;
        case (sec)
          SEC_HP:  cf = -b0;
          SEC_BP:  cf = '0;
          SEC_NO:  cf = a1;
          default: cf = b0;
        endcase
      end
      3'd2: begin tap = TAP_X2; dat = rdata; cf = (sec == SEC_BP) ? -b0 : b0; end
      3'd3: begin tap = TAP_Y1; dat = rdata; cf = -a1; end
      3'd4: begin tap = TAP_Y2; dat = rdata; cf = -a2; end
      default: ;
    endcase
  end

  // the one multiplier; b1 of 2b0 / -2b0 is applied by doubling
  logic signed [51:0] prod;
  logic dbl;
  assign dbl = (step == 3'd1) && (sec != SEC_NO) && (sec != SEC_BP);
  assign prod = 52'(cf) * 52'(dat);

  // round and saturate acc
  logic signed [ACC_BITS-1:0] rnd;
  logic signed [31:0] ysat;
  always_comb begin
    rnd = (acc + (64'sd1 <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
    if (rnd > 64'sd2147483647) ysat = 32'sh7fffffff;
    else if (rnd < -64'sd2147483648) ysat = 32'sh80000000;
    else ysat = rnd[31:0];
  end

  // next enabled section from sec+1
  logic [2:0] nxt;
  logic nxt_ok;
  always_comb begin
    nxt = sec;
    nxt_ok = 1'b0;
    for (int i = NUM_SECT - 1; i >= 0; i--) begin
      if (i > int'(sec) && enable_mask[i]) begin
        nxt = 3'(i);
        nxt_ok = 1'b1;
      end
    end
  end

  logic signed [32:0] mix;
  assign mix = 33'(ycas) + 33'(ysat);

  assign in_ready  = (state == ST_IDLE) && !out_valid;
  assign cfg_ready = 1'b1;
  assign sample_out = res;

  // read address set in the cycle before the mac step that uses the tap
  always_comb begin
    raddr = hist_addr(ch, sec, tap);
    we = 1'b0;
    waddr = clr_addr;
    wdata = '0;
    case (state)
      ST_CLEAR: we = 1'b1;
      ST_SEL:   raddr = hist_addr(ch, sec, TAP_X1);
      ST_RD:    raddr = hist_addr(ch, sec, TAP_X2);
      ST_MAC: begin
        case (step)
          3'd0: raddr = hist_addr(ch, sec, TAP_X1);
          3'd1: raddr = hist_addr(ch, sec, TAP_X2);
          3'd2: raddr = hist_addr(ch, sec, TAP_Y1);
          default: raddr = hist_addr(ch, sec, TAP_Y2);
        endcase
      end
      ST_WB: begin
        we = 1'b1;
        case (step)
          3'd0: begin waddr = hist_addr(ch, sec, TAP_X2); wdata = h0; end
          3'd1: begin waddr = hist_addr(ch, sec, TAP_X1); wdata = xcur; end
          3'd2: begin waddr = hist_addr(ch, sec, TAP_Y2); wdata = h2; end
          default: begin waddr = hist_addr(ch, sec, TAP_Y1); wdata = ysat; end
        endcase
      end
      default: ;
    endcase
  end

  // output saturation of a value
  function automatic logic signed [SAMPLE_BITS-1:0] osat(logic signed [32:0] v);
    if (v > 33'(FULL)) return FULL;
    if (v < -33'(FULL)) return -FULL;
    return v[SAMPLE_BITS-1:0];
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SECT; i++) coefs[i] <= '0;
      enable_mask <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_HP, REG_LP, REG_BP, REG_NO, REG_PAR: coefs[cfg_index] <= cfg_data;
        REG_MASK: enable_mask <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_addr <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(DEPTH - 1)) state <= ST_IDLE;
        end
        ST_IDLE: if (in_valid && in_ready) begin
          xin <= 32'(sample_in);
          xcur <= 32'(sample_in);
          ycas <= 32'(sample_in);
          ch <= (32'(channel) >= CHANNELS) ? CW'(CHANNELS - 1) : CW'(channel);
          sec <= '0;
          state <= ST_SEL;
        end
        ST_SEL: begin
          // find first enabled section at or after sec
          if (enable_mask[sec]) begin
            if (sec == SEC_PAR) xcur <= xin;
            state <= ST_RD;
          end else if (sec == SEC_PAR) begin
            res <= osat(33'(ycas));
            state <= ST_DONE;
          end else begin
            sec <= sec + 1'b1;
          end
        end
        ST_RD: begin
          acc <= '0;
          step <= '0;
          state <= ST_MAC;
        end
        ST_MAC: begin
          acc <= acc + (dbl ? 64'(prod) <<< 1 : 64'(prod));
          if (step == 3'd1) h0 <= rdata;
          if (step == 3'd3) h2 <= rdata;
          step <= step + 1'b1;
          if (step == 3'd4) begin
            step <= '0;
            state <= ST_WB;
          end
        end
        ST_WB: begin
          step <= step + 1'b1;
          if (step == 3'd3) begin
            if (sec == SEC_PAR) begin
              res <= osat(mix >>> 1);
              state <= ST_DONE;
            end else begin
              ycas <= ysat;
              // the parallel section filters the raw input
              xcur <= (nxt == SEC_PAR) ? xin : ysat;
              if (nxt_ok) begin
                sec <= nxt;
                state <= ST_RD;
              end else begin
                res <= osat(33'(ysat));
                state <= ST_DONE;
              end
            end
          end
        end
        ST_DONE: begin
          out_valid <= 1'b1;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

>>> src/sbqm_ram.sv
// generic ram with one write port and one registered read port
// no dependencies
module sbqm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 40
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
